// File: rtl/core/lpfr_pkg.sv
package lpfr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Register reset values
  localparam logic [7:0]  HEADER_RST  = 8'hA5;
  localparam logic [6:0]  MAX_LEN_RST = 7'd64;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;

  // Request kinds on the input channel
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start_frame;  // header seen: seed the sum
    logic take_len;     // latch length, add to sum, clear count
    logic take_data;    // store payload byte, add to sum, advance count
    logic clr_idle;     // a byte arrived: clear the idle counter
    logic tick;         // a tick arrived inside a frame
    logic save_ok;      // checksum byte: latch the compare, rewind count
    logic clr_cnt;      // drop back to hunting
    logic rd_issue;     // read the store at the current count
    logic load_out;     // move read data into the output register
    logic load_empty;   // load the empty-frame marker
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_header;
    logic len_bad;
    logic data_more;
    logic timeout;
    logic len_zero;
    logic rd_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/core/lpfr_ram.sv
module lpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lpfr_ctrl.sv
module lpfr_ctrl
  import lpfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_HUNT  = 3'd0;
  localparam logic [2:0] S_LEN   = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LD    = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc, acc_byte, acc_tick;

  assign in_ready = (state_r == S_HUNT) || (state_r == S_LEN) || (state_r == S_DATA);
  assign acc      = in_valid && in_ready;
  assign acc_byte = acc && (in_req_type == REQ_BYTE);
  assign acc_tick = acc && (in_req_type == REQ_TICK);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_HUNT: begin
        if (acc_byte && stat.is_header) begin
          cmd.start_frame = 1'b1;
          state_nxt       = S_LEN;
        end
      end
      S_LEN, S_DATA: begin
        if (acc_tick) begin
          cmd.tick = 1'b1;
          if (stat.timeout) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = S_HUNT;
          end
        end else if (acc_byte) begin
          cmd.clr_idle = 1'b1;
          if (state_r == S_LEN) begin
            if (stat.len_bad) begin
              cmd.clr_cnt = 1'b1;
              state_nxt   = S_HUNT;
            end else begin
              cmd.take_len = 1'b1;
              state_nxt    = S_DATA;
            end
          end else if (stat.data_more) begin
            cmd.take_data = 1'b1;
          end else begin
            cmd.save_ok = 1'b1;
            state_nxt   = stat.len_zero ? S_EMPTY : S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LD;
      end
      S_LD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          if (stat.rd_last) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = S_HUNT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = S_HUNT;
        end
      end
      default: begin
        state_nxt = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/lpfr_dp.sv
module lpfr_dp
  import lpfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [7:0]  in_rx_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_byte_index,
  output logic [6:0]  out_frame_length,
  output logic        out_last_of_frame,
  output logic        out_checksum_ok,
  output logic        out_no_payload
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]  header_r;
  logic [6:0]  max_len_r;
  logic [15:0] timeout_r;
  logic [6:0]  exp_r, exp_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] idle_inc;
  logic        ok_r;
  logic        out_valid_r;
  logic [7:0]  payload_r;
  logic [5:0]  index_r;
  logic [6:0]  length_r;
  logic        last_r, chk_r, empty_r;
  logic [7:0]  rd_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RST;
      max_len_r <= MAX_LEN_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER:  header_r  <= cfg_wdata[7:0];
        REG_MAX_LEN: max_len_r <= cfg_wdata[6:0];
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  assign stat.is_header = (in_rx_byte == header_r);
  assign stat.len_bad   = (in_rx_byte > {1'b0, max_len_r}) ||
                          (in_rx_byte > 8'(MAX_PAYLOAD));
  assign stat.data_more = (cnt_r < exp_r);
  assign stat.timeout   = (idle_inc > timeout_r);
  assign stat.len_zero  = (exp_r == 7'd0);
  assign stat.rd_last   = ((cnt_r + 7'd1) == exp_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    idle_nxt = idle_r;
    if (cmd.start_frame) begin
      sum_nxt = header_r;
    end
    if (cmd.take_len) begin
      exp_nxt = in_rx_byte[6:0];
      cnt_nxt = 7'd0;
      sum_nxt = sum_r + in_rx_byte;
    end
    if (cmd.take_data) begin
      cnt_nxt = cnt_r + 7'd1;
      sum_nxt = sum_r + in_rx_byte;
    end
    if (cmd.load_out) begin
      cnt_nxt = cnt_r + 7'd1;
    end
    if (cmd.save_ok || cmd.clr_cnt) begin
      cnt_nxt = 7'd0;
    end
    if (cmd.clr_idle) begin
      idle_nxt = 16'd0;
    end
    if (cmd.tick) begin
      idle_nxt = stat.timeout ? 16'd0 : idle_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r       <= 7'd0;
      cnt_r       <= 7'd0;
      sum_r       <= 8'd0;
      idle_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      exp_r  <= exp_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      idle_r <= idle_nxt;
      if (cmd.load_out || cmd.load_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.save_ok) begin
      ok_r <= (in_rx_byte == sum_r);
    end
    if (cmd.load_out) begin
      payload_r <= rd_data;
      index_r   <= cnt_r[5:0];
      length_r  <= exp_r;
      last_r    <= stat.rd_last;
      chk_r     <= ok_r;
      empty_r   <= 1'b0;
    end else if (cmd.load_empty) begin
      payload_r <= 8'd0;
      index_r   <= 6'd0;
      length_r  <= 7'd0;
      last_r    <= 1'b1;
      chk_r     <= ok_r;
      empty_r   <= 1'b1;
    end
  end

  lpfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.take_data),
    .waddr(AW'(cnt_r)),
    .wdata(in_rx_byte),
    .re   (cmd.rd_issue),
    .raddr(AW'(cnt_r)),
    .rdata(rd_data)
  );

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = payload_r;
  assign out_byte_index    = index_r;
  assign out_frame_length  = length_r;
  assign out_last_of_frame = last_r;
  assign out_checksum_ok   = chk_r;
  assign out_no_payload    = empty_r;

  a_cnt_within_len: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= exp_r)
    else $error("payload count ran past frame length");

  a_len_within_store: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, exp_r} <= 8'(MAX_PAYLOAD))
    else $error("frame length exceeds store depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out || cmd.load_empty) |-> stat.out_free)
    else $error("output register loaded over a pending result");

  a_store_idle_on_replay: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> !cmd.take_data && !cmd.save_ok)
    else $error("store written while replaying a frame");

endmodule

// File: rtl/core/length_prefixed_frame_receiver.sv
// Channel   Direction  Handshake               Payload
// in_       input      in_valid / in_ready     in_req_type, in_rx_byte
// out_      output     out_valid / out_ready   payload byte, index, length, flags
// cfg_      input      cfg_we (no wait)        cfg_index, cfg_wdata
//
// Byte and tick requests are accepted while hunting or collecting a frame.
// The checksum byte starts a replay: each stored byte takes a store read,
// then an output load that waits while out_ready stalls; a zero-length frame
// instead gives its single marker result. in_ready is low during replay.
// Reset (rst_n, synchronous) restores the register defaults and hunting.
// The payload store needs no clearing pass: only written entries are read.
module length_prefixed_frame_receiver
  import lpfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // received bytes and millisecond ticks
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_rx_byte,
  // released frame bytes
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic [5:0]  out_byte_index,
  output logic [6:0]  out_frame_length,
  output logic        out_last_of_frame,
  output logic        out_checksum_ok,
  output logic        out_no_payload
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: hunt, length, payload/checksum, then replay the stored frame or emit the empty-frame marker
  lpfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_req_type(in_req_type),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: registers, running sum, idle timer, payload store, output stage
  lpfr_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_length (out_frame_length),
    .out_last_of_frame(out_last_of_frame),
    .out_checksum_ok  (out_checksum_ok),
    .out_no_payload   (out_no_payload)
  );

endmodule
